FILE: sv/lfucp_pkg.sv
// ============================================================================
// lfucp_pkg: shared constants and types for the LFU cache policy unit
// Sizes of the entry store, field widths, request codes and the command and
// status bundles between controller and datapath.
// ============================================================================
package lfucp_pkg;

   // Store geometry
   localparam int ENTRIES    = 16;
   localparam int COUNT_BITS = 16;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_BITS   = $clog2(ENTRIES + 1);
   localparam int RANK_BITS  = IDX_BITS;

   // Field widths
   localparam int KEY_BITS  = 32;
   localparam int DATA_BITS = 32;
   localparam int CAP_BITS  = 5;

   localparam logic [CAP_BITS-1:0]   CAP_RESET = CAP_BITS'(16);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Request codes
   localparam logic ACTION_GET = 1'b0;
   localparam logic ACTION_PUT = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic                capture;   // latch the accepted request, clear trackers
      logic                rd_en;     // issue a key read
      logic [IDX_BITS-1:0] rd_idx;
      logic                cmp_en;    // compare the key read back last cycle
      logic [IDX_BITS-1:0] cmp_idx;
      logic                commit;    // apply the update to the store
      logic                data_rd;   // read data of the hit entry
      logic                load_rsp;  // load the result register
   } lfucp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic get_hit;
   } lfucp_sts_type;

endpackage

FILE: sv/lfucp_if.sv
// ============================================================================
// lfucp_if: request and response channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ============================================================================
interface lfucp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 action;
   logic        [lfucp_pkg::KEY_BITS-1:0]  lookup_key;
   logic signed [lfucp_pkg::DATA_BITS-1:0] write_data;

   modport source (output valid, action, lookup_key, write_data, input ready);
   modport sink   (input valid, action, lookup_key, write_data, output ready);
endinterface

interface lfucp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 hit;
   logic signed [lfucp_pkg::DATA_BITS-1:0] read_data;
   logic                                 evicted;
   logic        [lfucp_pkg::KEY_BITS-1:0]  evicted_key;

   modport source (output valid, hit, read_data, evicted, evicted_key, input ready);
   modport sink   (input valid, hit, read_data, evicted, evicted_key, output ready);
endinterface

FILE: sv/lfucp_ctrl.sv
// ============================================================================
// lfucp_ctrl: request sequencer
// Accepts a request, walks the key scan, orders commit, data read and the
// load of the result register, and runs the response handshake.
// ============================================================================
module lfucp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  lfucp_pkg::lfucp_sts_type sts,
   output lfucp_pkg::lfucp_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_COMMIT = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   localparam logic [lfucp_pkg::OCC_BITS-1:0] SCAN_LAST =
      lfucp_pkg::OCC_BITS'(lfucp_pkg::ENTRIES);

   logic [2:0]                     state_ff, state_in;
   logic [lfucp_pkg::OCC_BITS-1:0] cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           req_xfer;
   logic                           rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      cmd.rd_idx   = cnt_ff[lfucp_pkg::IDX_BITS-1:0];
      cmd.cmp_idx  = lfucp_pkg::IDX_BITS'(cnt_ff - 1'b1);
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_xfer) begin
               cmd.capture = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en  = (cnt_ff < SCAN_LAST);
            cmd.cmp_en = (cnt_ff != '0);
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == SCAN_LAST) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = sts.get_hit ? ST_READ : ST_RESP;
         end
         ST_READ: begin
            cmd.data_rd = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result valid until the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Never overwrite a result that is still waiting
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> rsp_free)
      else $error("result register loaded while occupied");

   // Scan counter stays within the scan length
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= SCAN_LAST))
      else $error("scan counter out of range");

endmodule

FILE: sv/lfucp_datapath.sv
// ============================================================================
// lfucp_datapath: entry store, scan trackers and update logic
// Keys and data sit in memories with registered reads; valid bits, use
// counts and recency ranks are per-entry registers updated in parallel.
// ============================================================================
module lfucp_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  lfucp_pkg::lfucp_cmd_type                 cmd,
   output lfucp_pkg::lfucp_sts_type                 sts,
   input  logic                                     csr_write_enable,
   input  logic        [lfucp_pkg::CAP_BITS-1:0]    csr_write_data,
   input  logic                                     req_action,
   input  logic        [lfucp_pkg::KEY_BITS-1:0]    req_lookup_key,
   input  logic signed [lfucp_pkg::DATA_BITS-1:0]   req_write_data,
   output logic                                     rsp_hit,
   output logic signed [lfucp_pkg::DATA_BITS-1:0]   rsp_read_data,
   output logic                                     rsp_evicted,
   output logic        [lfucp_pkg::KEY_BITS-1:0]    rsp_evicted_key
);

   localparam int N  = lfucp_pkg::ENTRIES;
   localparam int IB = lfucp_pkg::IDX_BITS;
   localparam int OB = lfucp_pkg::OCC_BITS;
   localparam int RB = lfucp_pkg::RANK_BITS;
   localparam int CB = lfucp_pkg::COUNT_BITS;
   localparam int KB = lfucp_pkg::KEY_BITS;
   localparam int DB = lfucp_pkg::DATA_BITS;

   // Configuration
   logic [lfucp_pkg::CAP_BITS-1:0] cap_ff;
   logic [OB-1:0]                  cap_eff;

   // Latched request
   logic                 act_ff;
   logic [KB-1:0]        key_ff;
   logic signed [DB-1:0] wdata_ff;

   // Memories and their read registers
   logic [KB-1:0]        key_mem [N];
   logic signed [DB-1:0] data_mem [N];
   logic [KB-1:0]        key_rd_ff;
   logic signed [DB-1:0] data_rd_ff;

   // Per-entry state
   logic [N-1:0]  valid_ff, valid_in;
   logic [CB-1:0] count_ff [N];
   logic [CB-1:0] count_in [N];
   logic [RB-1:0] rank_ff [N];
   logic [RB-1:0] rank_in [N];
   logic [OB-1:0] occ_ff, occ_in;

   // Scan trackers
   logic          found_ff;
   logic [IB-1:0] hit_slot_ff;
   logic [CB-1:0] hit_cnt_ff;
   logic [RB-1:0] hit_rank_ff;
   logic          free_found_ff;
   logic [IB-1:0] free_slot_ff;
   logic          vic_found_ff;
   logic [IB-1:0] vic_slot_ff;
   logic [CB-1:0] vic_cnt_ff;
   logic [RB-1:0] vic_rank_ff;
   logic [KB-1:0] vic_key_ff;

   // Compare stage
   logic          cmp_valid;
   logic          cmp_match;
   logic          cmp_better;
   logic [CB-1:0] cmp_cnt;
   logic [RB-1:0] cmp_rank;

   // Commit decisions
   logic          put_on;
   logic          do_touch;
   logic          do_evict;
   logic          do_ins;
   logic [IB-1:0] ins_slot;
   logic          data_we;
   logic [IB-1:0] data_wa;

   // Result staging
   logic          res_hit_ff;
   logic          res_evicted_ff;
   logic [KB-1:0] res_evkey_ff;

   // Result register
   logic                 rsp_hit_ff;
   logic signed [DB-1:0] rsp_read_data_ff;
   logic                 rsp_evicted_ff;
   logic [KB-1:0]        rsp_evkey_ff;

   assign cap_eff = (32'(cap_ff) > 32'(N)) ? OB'(N) : OB'(cap_ff);

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lfucp_pkg::CAP_RESET;
      end else if (csr_write_enable) begin
         cap_ff <= csr_write_data;
      end
   end

   // Latch request on transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= req_action;
         key_ff   <= req_lookup_key;
         wdata_ff <= req_write_data;
      end
   end

   // Compare one entry against the key and the current victim
   assign cmp_valid  = valid_ff[cmd.cmp_idx];
   assign cmp_cnt    = count_ff[cmd.cmp_idx];
   assign cmp_rank   = rank_ff[cmd.cmp_idx];
   assign cmp_match  = cmp_valid && (key_rd_ff == key_ff);
   assign cmp_better = cmp_valid && (!vic_found_ff || (cmp_cnt < vic_cnt_ff) ||
                       ((cmp_cnt == vic_cnt_ff) && (cmp_rank > vic_rank_ff)));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         vic_found_ff  <= 1'b0;
      end else if (cmd.cmp_en) begin
         if (cmp_match && !found_ff) begin
            found_ff    <= 1'b1;
            hit_slot_ff <= cmd.cmp_idx;
            hit_cnt_ff  <= cmp_cnt;
            hit_rank_ff <= cmp_rank;
         end
         if (!cmp_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_slot_ff  <= cmd.cmp_idx;
         end
         if (cmp_better) begin
            vic_found_ff <= 1'b1;
            vic_slot_ff  <= cmd.cmp_idx;
            vic_cnt_ff   <= cmp_cnt;
            vic_rank_ff  <= cmp_rank;
            vic_key_ff   <= key_rd_ff;
         end
      end
   end

   // Decide what the request does
   assign put_on   = (act_ff == lfucp_pkg::ACTION_PUT) && (cap_eff != '0);
   assign do_touch = found_ff && ((act_ff == lfucp_pkg::ACTION_GET) || put_on);
   assign do_evict = put_on && !found_ff && (occ_ff >= cap_eff) && vic_found_ff;
   assign do_ins   = put_on && !found_ff && (do_evict || free_found_ff);
   assign ins_slot = do_evict ? vic_slot_ff : free_slot_ff;
   assign data_we  = cmd.commit && ((do_touch && put_on) || do_ins);
   assign data_wa  = do_ins ? ins_slot : hit_slot_ff;

   assign sts.get_hit = found_ff && (act_ff == lfucp_pkg::ACTION_GET);

   // Per-entry next state: touch, or evict and insert
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < N; i++) begin
         rank_in[i]  = rank_ff[i];
         count_in[i] = count_ff[i];
         if (cmd.commit && do_touch) begin
            if (IB'(i) == hit_slot_ff) begin
               rank_in[i] = '0;
               if (hit_cnt_ff != lfucp_pkg::COUNT_MAX) begin
                  count_in[i] = hit_cnt_ff + 1'b1;
               end
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank_ff)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end else if (cmd.commit && do_ins) begin
            if (IB'(i) == ins_slot) begin
               rank_in[i]  = '0;
               count_in[i] = CB'(1);
               valid_in[i] = 1'b1;
            end else if (valid_ff[i]) begin
               if (do_evict && (rank_ff[i] > vic_rank_ff)) begin
                  rank_in[i] = rank_ff[i];
               end else begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
            end
         end
      end
      if (cmd.commit && do_ins && !do_evict) begin
         occ_in = occ_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         rank_ff[i]  <= rank_in[i];
         count_ff[i] <= count_in[i];
      end
   end

   // Key memory: scan read, insert write
   always_ff @(posedge clock) begin
      if (cmd.commit && do_ins) begin
         key_mem[ins_slot] <= key_ff;
      end
      if (cmd.rd_en) begin
         key_rd_ff <= key_mem[cmd.rd_idx];
      end
   end

   // Data memory: put write, get-hit read
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_wa] <= wdata_ff;
      end
      if (cmd.data_rd) begin
         data_rd_ff <= data_mem[hit_slot_ff];
      end
   end

   // Stage result flags at commit
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         res_hit_ff     <= do_touch;
         res_evicted_ff <= do_evict;
         res_evkey_ff   <= do_evict ? vic_key_ff : '0;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_hit_ff       <= res_hit_ff;
         rsp_read_data_ff <= (res_hit_ff && (act_ff == lfucp_pkg::ACTION_GET)) ?
                             data_rd_ff : '0;
         rsp_evicted_ff   <= res_evicted_ff;
         rsp_evkey_ff     <= res_evkey_ff;
      end
   end

   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evkey_ff;

   // Fill count tracks the valid bits
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(occ_ff))
      else $error("fill count disagrees with valid bits");

   // Store never holds more than its depth
   a_occ_max: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= N)
      else $error("fill count above store depth");

   // A request either touches an entry or inserts one, never both
   a_touch_ins: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(do_touch && do_ins))
      else $error("touch and insert in one commit");

   // An eviction leaves the fill count unchanged
   a_evict_occ: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && do_evict) |=> $stable(occ_ff))
      else $error("fill count moved on eviction");

endmodule

FILE: sv/lfu_cache_policy_unit.sv
// ============================================================================
// lfu_cache_policy_unit: LFU key-value store with LRU tie break
// Get and put requests against a 16-entry store; a put to a new key on a
// full store evicts the least used, least recent entry.
// ============================================================================
//
//   Channel   Dir  Handshake           Payload
//   req_chan  in   valid/ready         action, lookup_key, write_data
//   rsp_chan  out  valid/ready         hit, read_data, evicted, evicted_key
//   csr_*     in   write enable only   capacity_in_use (5 bits)
//
// A request runs through the key scan, one entry per cycle through the key
// memory port (16 reads, each key compared after its read), then commit, the
// data read on a get hit, and the load of the result register.
// One request is in flight at a time; the next one is taken while the last
// result still waits in the result register.
// Reset clears the valid bits and fill count and sets capacity to 16; keys,
// data, counts and ranks need no clearing pass.
// A stalled response holds the unit before the load of the result register.
module lfu_cache_policy_unit (
   input  logic                               clock,
   input  logic                               reset,
   lfucp_req_if.sink                          req_chan,
   lfucp_rsp_if.source                        rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [lfucp_pkg::CAP_BITS-1:0]     csr_write_data
);

   lfucp_pkg::lfucp_cmd_type cmd;
   lfucp_pkg::lfucp_sts_type sts;

   // Sequencer
   lfucp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Store and update logic
   lfucp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_action       (req_chan.action),
      .req_lookup_key   (req_chan.lookup_key),
      .req_write_data   (req_chan.write_data),
      .rsp_hit          (rsp_chan.hit),
      .rsp_read_data    (rsp_chan.read_data),
      .rsp_evicted      (rsp_chan.evicted),
      .rsp_evicted_key  (rsp_chan.evicted_key)
   );

endmodule

FILE: sim/lfu_policy_checker.sv
// ============================================================================
// lfu_policy_checker: predicts and checks lookups of the LFU cache policy unit
// Watches the request, response and capacity ports, keeps its own copy of the
// entry store, works out the result of every request transfer and compares
// each response transfer, field by field, with the oldest prediction.
// ============================================================================
module lfu_policy_checker
   import lfucp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   lfucp_req_if                req_chan,
   lfucp_rsp_if                rsp_chan,
   input  logic                csr_write_enable,
   input  logic [CAP_BITS-1:0] csr_write_data,
   output int                  fail_count,
   output int                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                 hit;
      logic [DATA_BITS-1:0] read_data;
      logic                 evicted;
      logic [KEY_BITS-1:0]  evicted_key;
   } lookup_result_t;

   // Shadow copy of the store
   logic                  slot_valid [ENTRIES];
   logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
   logic [DATA_BITS-1:0]  slot_data  [ENTRIES];
   logic [COUNT_BITS-1:0] slot_count [ENTRIES];
   logic [RANK_BITS-1:0]  slot_rank  [ENTRIES];
   int                    fill;
   logic [CAP_BITS-1:0]   capacity;

   lookup_result_t expected_lookups [$];

   function automatic int find_slot(logic [KEY_BITS-1:0] key);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && slot_key[i] == key)
            return i;
      return -1;
   endfunction

   // Make the slot the most recent one and raise its count
   function automatic void touch_slot(int s);
      logic [RANK_BITS-1:0] r;
      r = slot_rank[s];
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && slot_rank[i] < r)
            slot_rank[i]++;
      slot_rank[s] = '0;
      if (slot_count[s] != COUNT_MAX)
         slot_count[s]++;
   endfunction

   // Lowest count, oldest among equals
   function automatic int choose_victim();
      int v;
      v = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!slot_valid[i])
            continue;
         if (v < 0 || slot_count[i] < slot_count[v] ||
             (slot_count[i] == slot_count[v] && slot_rank[i] > slot_rank[v]))
            v = i;
      end
      return v;
   endfunction

   function automatic lookup_result_t predict_lookup(logic act, logic [KEY_BITS-1:0] key,
                                                     logic [DATA_BITS-1:0] data);
      lookup_result_t       res;
      int                   cap_eff;
      int                   s;
      logic [RANK_BITS-1:0] r;
      res     = '0;
      cap_eff = (capacity > ENTRIES) ? ENTRIES : int'(capacity);
      s       = find_slot(key);

      // Get: touch and return data on a hit, nothing on a miss
      if (act == ACTION_GET) begin
         if (s >= 0) begin
            touch_slot(s);
            res.hit       = 1'b1;
            res.read_data = slot_data[s];
         end
         return res;
      end

      // Capacity zero drops every put
      if (cap_eff == 0)
         return res;

      // Put to a present key: replace the data and touch
      if (s >= 0) begin
         slot_data[s] = data;
         touch_slot(s);
         res.hit = 1'b1;
         return res;
      end

      // Store full: evict one victim and close the gap in the ranks
      s = -1;
      if (fill >= cap_eff) begin
         s = choose_victim();
         if (s >= 0) begin
            r               = slot_rank[s];
            res.evicted     = 1'b1;
            res.evicted_key = slot_key[s];
            slot_valid[s]   = 1'b0;
            fill--;
            for (int i = 0; i < ENTRIES; i++)
               if (slot_valid[i] && slot_rank[i] > r)
                  slot_rank[i]--;
         end
      end
      for (int i = 0; i < ENTRIES && s < 0; i++)
         if (!slot_valid[i])
            s = i;
      if (s < 0)
         return res;

      // Insert as the most recent entry with count one
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i])
            slot_rank[i]++;
      slot_valid[s] = 1'b1;
      slot_key[s]   = key;
      slot_data[s]  = data;
      slot_count[s] = COUNT_BITS'(1);
      slot_rank[s]  = '0;
      fill++;
      return res;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endfunction

   // Compare response transfers, predict request transfers, track capacity
   always @(posedge clock) begin
      lookup_result_t want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++)
            slot_valid[i] = 1'b0;
         fill       = 0;
         capacity   = CAP_RESET;
         fail_count = 0;
         expected_lookups.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_lookups.size() == 0) begin
               $error("response transfer with no request outstanding");
               fail_count++;
            end else begin
               want = expected_lookups.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_chan.hit));
               check_field("read_data", want.read_data, rsp_chan.read_data);
               check_field("evicted", 32'(want.evicted), 32'(rsp_chan.evicted));
               check_field("evicted_key", want.evicted_key, rsp_chan.evicted_key);
            end
         end
         if (req_chan.valid && req_chan.ready)
            expected_lookups.push_back(predict_lookup(req_chan.action, req_chan.lookup_key,
                                                      req_chan.write_data));
         if (csr_write_enable)
            capacity = csr_write_data;
      end
      outstanding = expected_lookups.size();
   end

endmodule

FILE: sim/tb.sv
// ============================================================================
// tb: top level bench for the LFU cache policy unit
// Drives get and put requests through directed cases and randomized phases at
// several capacities and idle patterns, and gives the verdict from the count
// of mismatches reported by the checker.
// ============================================================================
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lfucp_pkg::*;

   localparam int     CLK_PERIOD      = 20;
   localparam int     RESET_CYCLES    = 8;
   localparam int     POOL_SIZE       = 24;
   localparam int     HOLD_OFF_CYCLES = 400;
   localparam int     DRAIN_CYCLES    = 60;
   localparam longint TIMEOUT_NS      = 20_000_000;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_enable;
   logic [CAP_BITS-1:0] csr_write_data;
   int                  fail_count;
   int                  outstanding;

   int                  src_idle_pct   = 0;
   int                  sink_stall_pct = 0;
   bit                  hold_off_request = 1'b0;
   logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

   lfucp_req_if req_chan ();
   lfucp_rsp_if rsp_chan ();

   lfu_cache_policy_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   lfu_policy_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Offer one request, idling first at the phase's rate, until it transfers
   task automatic send_request(input logic act, input logic [KEY_BITS-1:0] key,
                               input logic signed [DATA_BITS-1:0] data);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.action     <= act;
      req_chan.lookup_key <= key;
      req_chan.write_data <= data;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   // Write capacity once every result has come back
   task automatic write_capacity(input logic [CAP_BITS-1:0] value);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly keys from a small pool so hits and evictions happen; some fresh keys
   task automatic send_random_item(input int span);
      logic                act;
      logic [KEY_BITS-1:0] key;
      int                  idx;
      act = 1'($urandom_range(1));
      if ($urandom_range(99) < 12) begin
         key = $urandom;
      end else begin
         idx = $urandom_range(1) ? $urandom_range(span / 3) : $urandom_range(span);
         key = key_pool[idx];
      end
      send_request(act, key, $urandom);
   endtask

   task automatic run_segment(input logic [CAP_BITS-1:0] cap, input int src, input int snk,
                              input int count, input bit with_hold);
      int span;
      write_capacity(cap);
      src_idle_pct   = src;
      sink_stall_pct = snk;
      span = ((cap > ENTRIES) ? ENTRIES : int'(cap)) + 4;
      if (span > POOL_SIZE - 1)
         span = POOL_SIZE - 1;
      for (int n = 0; n < count; n++) begin
         if (with_hold && n == count / 2)
            hold_off_request = 1'b1;
         send_random_item(span);
      end
   endtask

   // Response side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      req_chan.valid      = 1'b0;
      req_chan.action     = ACTION_GET;
      req_chan.lookup_key = '0;
      req_chan.write_data = '0;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      reset               = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty store miss, field extremes, put hit replacing data
      send_request(ACTION_GET, 32'h0000_0000, 32'sh0000_0000);
      send_request(ACTION_PUT, 32'h0000_0000, 32'sh7FFF_FFFF);
      send_request(ACTION_PUT, 32'hFFFF_FFFF, 32'sh8000_0000);
      send_request(ACTION_GET, 32'h0000_0000, 32'sh0000_0000);
      send_request(ACTION_GET, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
      send_request(ACTION_PUT, 32'h0000_0000, 32'sh0000_0000);
      send_request(ACTION_GET, 32'h0000_0000, 32'shFFFF_FFFF);
      send_request(ACTION_PUT, 32'h0000_0000, 32'shFFFF_FFFF);
      send_request(ACTION_GET, 32'h0000_0000, 32'sh0000_0000);
      send_request(ACTION_GET, 32'h1234_5678, 32'sh0000_0000);

      // Full store: evict the least used entry
      write_capacity(CAP_BITS'(2));
      send_request(ACTION_PUT, 32'h0000_0005, 32'sh0000_0055);
      send_request(ACTION_PUT, 32'h0000_0006, 32'sh0000_0066);
      send_request(ACTION_GET, 32'h0000_0006, 32'sh0000_0000);
      send_request(ACTION_PUT, 32'h0000_0007, 32'sh0000_0077);

      // Equal counts: evict the older entry
      write_capacity(CAP_BITS'(3));
      send_request(ACTION_PUT, 32'h0000_0008, 32'sh0000_0088);
      send_request(ACTION_PUT, 32'h0000_0009, 32'sh0000_0099);

      // Capacity zero drops puts, gets still hit
      write_capacity(CAP_BITS'(0));
      send_request(ACTION_PUT, 32'h0000_000A, 32'sh0000_00AA);
      send_request(ACTION_GET, 32'h0000_0000, 32'sh0000_0000);
      send_request(ACTION_GET, 32'h0000_0009, 32'sh0000_0000);

      // Capacity above the entry count
      write_capacity(CAP_BITS'(31));
      send_request(ACTION_PUT, 32'hA5A5_5A5A, 32'sh5A5A_A5A5);

      // Randomized phases
      run_segment(CAP_BITS'(16), 0,  0,  120, 1'b0);
      run_segment(CAP_BITS'(31), 71, 0,  100, 1'b0);
      run_segment(CAP_BITS'(4),  0,  71, 100, 1'b0);
      run_segment(CAP_BITS'(1),  10, 10, 60,  1'b0);
      run_segment(CAP_BITS'(16), 10, 10, 120, 1'b1);
      run_segment(CAP_BITS'(3),  71, 0,  80,  1'b0);
      run_segment(CAP_BITS'(0),  0,  71, 40,  1'b0);
      run_segment(CAP_BITS'(17), 0,  0,  130, 1'b0);

      // Drain and let the unit settle
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
sv/lfucp_pkg.sv
sv/lfucp_if.sv
sv/lfucp_ctrl.sv
sv/lfucp_datapath.sv
sv/lfu_cache_policy_unit.sv
sim/lfu_policy_checker.sv
sim/tb.sv
